// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Relies on the including module to have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLKED(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// Types, codes and helper functions for the JSON string unescaper.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package jsu_pkg;

    // Decoder mode codes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX0   = 3'd2,
        MODE_HEX1   = 3'd3,
        MODE_HEX2   = 3'd4,
        MODE_HEX3   = 3'd5,
        MODE_STOP   = 3'd6
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef logic [7:0] t_byte;

    localparam t_byte CHR_NUL   = 8'h00;
    localparam t_byte CHR_QUOTE = 8'h22;
    localparam t_byte CHR_BSL   = 8'h5c;
    localparam t_byte CHR_SLASH = 8'h2f;
    localparam t_byte CHR_U     = 8'h75;

    localparam logic [14:0] WRITTEN_MAX = 15'h7fff;
    localparam logic [15:0] BUF_SIZE_RST = 16'd256;

    // Hex digit decode: bit 4 set when the byte is a valid digit.
    function automatic logic [4:0] hex_digit(input t_byte c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Single-letter escapes: bit 8 set when the letter is known.
    function automatic logic [8:0] simple_escape(input t_byte c);
        logic [8:0] r;
        unique case (c)
            8'h6e:     r = {1'b1, 8'h0a};
            8'h72:     r = {1'b1, 8'h0d};
            8'h74:     r = {1'b1, 8'h09};
            8'h62:     r = {1'b1, 8'h08};
            8'h66:     r = {1'b1, 8'h0c};
            CHR_QUOTE: r = {1'b1, CHR_QUOTE};
            CHR_BSL:   r = {1'b1, CHR_BSL};
            CHR_SLASH: r = {1'b1, CHR_SLASH};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/jsu_if.sv
// Valid/ready channel interfaces for the JSON string unescaper.
// Depends on jsu_pkg for the byte type.
`default_nettype none

interface jsu_in_if;
    logic           valid;
    logic           ready;
    logic           start_req;
    jsu_pkg::t_byte in_byte;

    modport source (output valid, output start_req, output in_byte, input ready);
    modport sink   (input valid, input start_req, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic           valid;
    logic           ready;
    jsu_pkg::t_byte out_byte0;
    jsu_pkg::t_byte out_byte1;
    jsu_pkg::t_byte out_byte2;
    logic [1:0]     byte_count;
    logic [1:0]     decode_status;

    modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                    output byte_count, output decode_status, input ready);
    modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                    input byte_count, input decode_status, output ready);
endinterface

`default_nettype wire

// File: rtl/json_string_unescape_core.sv
// JSON string unescaper top level: decoder state, result register, APB register.
// Depends on jsu_pkg, jsu_if.sv and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Decodes the body of a JSON string one text byte per transfer, starting just
// after the opening quote. Set start_req on the first byte of each string.
// Escapes \n \r \t \b \f \" \\ \/ and \uXXXX (hex in either case) are decoded;
// a \u code point leaves as one to three UTF-8 bytes in one result. Every input
// transfer yields exactly one result transfer carrying up to three bytes, a
// count and a status (running, done at the closing quote, error on an unknown
// escape, a bad hex digit or a NUL end of text). Once done or error, later
// bytes give count 0 and the held status until the next start_req. At most
// buffer_size minus one bytes (and never more than 32767) are emitted per
// string; the rest are dropped without a status change. Throughput is one
// byte per clock while the result register keeps draining: the decode is a
// single pass of logic from the input channel and the decoder state into the
// result register, and input is taken whenever that register is empty or
// being drained in the same cycle. buffer_size sits at APB byte address 0
// and must only be written while no string bytes are in flight.
module json_string_unescape_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    jsu_in_if.sink           i_in,
    jsu_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Decoder state
    jsu_pkg::t_mode   r_mode,    n_mode;
    logic [11:0]      r_accum,   n_accum;
    logic [14:0]      r_written, n_written;
    jsu_pkg::t_status r_final,   n_final;
    logic [15:0]      r_buf_size;

    // Result register
    logic             r_out_valid;
    jsu_pkg::t_byte   r_b0, r_b1, r_b2;
    logic [1:0]       r_cnt;
    jsu_pkg::t_status r_status;

    logic in_xfer;
    logic out_xfer;

    // Working copies after an optional start_req clear
    jsu_pkg::t_mode   cur_mode;
    logic [11:0]      cur_accum;
    logic [14:0]      cur_written;
    jsu_pkg::t_status cur_final;

    jsu_pkg::t_byte   c;
    logic [4:0]       hex;
    logic [8:0]       esc;
    logic [15:0]      cp;
    jsu_pkg::t_byte   cand0, cand1, cand2;
    logic [1:0]       cand_n;

    logic [15:0]      lim16;
    logic [14:0]      lim15;
    logic [14:0]      room;
    logic [1:0]       keep;

    jsu_pkg::t_byte   n_b0, n_b1, n_b2;
    jsu_pkg::t_status n_status;

    // Take a new byte whenever the result register is free or drains now.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = r_out_valid && o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte0     = r_b0;
    assign o_out.out_byte1     = r_b1;
    assign o_out.out_byte2     = r_b2;
    assign o_out.byte_count    = r_cnt;
    assign o_out.decode_status = r_status;

    // APB: single register, no wait states.
    assign pready = 1'b1;
    assign prdata = {16'd0, r_buf_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size <= jsu_pkg::BUF_SIZE_RST;
        end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
            r_buf_size <= pwdata[15:0];
        end
    end

    // Decode: start_req clears the state before the byte is looked at.
    always_comb begin
        c           = i_in.in_byte;
        cur_mode    = i_in.start_req ? jsu_pkg::MODE_NORMAL : r_mode;
        cur_accum   = i_in.start_req ? 12'd0 : r_accum;
        cur_written = i_in.start_req ? 15'd0 : r_written;
        cur_final   = i_in.start_req ? jsu_pkg::ST_RUN : r_final;

        hex = jsu_pkg::hex_digit(c);
        esc = jsu_pkg::simple_escape(c);
        cp  = {cur_accum, hex[3:0]};

        n_mode  = cur_mode;
        n_accum = cur_accum;
        n_final = cur_final;
        cand0   = 8'd0;
        cand1   = 8'd0;
        cand2   = 8'd0;
        cand_n  = 2'd0;

        unique case (cur_mode)
            jsu_pkg::MODE_NORMAL: begin
                priority if (c == jsu_pkg::CHR_NUL) begin
                    n_mode  = jsu_pkg::MODE_STOP;
                    n_final = jsu_pkg::ST_ERR;
                end else if (c == jsu_pkg::CHR_QUOTE) begin
                    n_mode  = jsu_pkg::MODE_STOP;
                    n_final = jsu_pkg::ST_DONE;
                end else if (c == jsu_pkg::CHR_BSL) begin
                    n_mode = jsu_pkg::MODE_ESCAPE;
                end else begin
                    cand0  = c;
                    cand_n = 2'd1;
                end
            end
            jsu_pkg::MODE_ESCAPE: begin
                priority if (esc[8]) begin
                    n_mode = jsu_pkg::MODE_NORMAL;
                    cand0  = esc[7:0];
                    cand_n = 2'd1;
                end else if (c == jsu_pkg::CHR_U) begin
                    n_mode  = jsu_pkg::MODE_HEX0;
                    n_accum = 12'd0;
                end else begin
                    n_mode  = jsu_pkg::MODE_STOP;
                    n_final = jsu_pkg::ST_ERR;
                end
            end
            jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                if (hex[4]) begin
                    n_accum = {cur_accum[7:0], hex[3:0]};
                    unique case (cur_mode)
                        jsu_pkg::MODE_HEX0: n_mode = jsu_pkg::MODE_HEX1;
                        jsu_pkg::MODE_HEX1: n_mode = jsu_pkg::MODE_HEX2;
                        default:            n_mode = jsu_pkg::MODE_HEX3;
                    endcase
                end else begin
                    n_mode  = jsu_pkg::MODE_STOP;
                    n_final = jsu_pkg::ST_ERR;
                end
            end
            jsu_pkg::MODE_HEX3: begin
                if (hex[4]) begin
                    // Last digit: encode the code point as UTF-8.
                    n_mode  = jsu_pkg::MODE_NORMAL;
                    n_accum = cp[11:0];
                    priority if (cp <= 16'h007f) begin
                        cand0  = cp[7:0];
                        cand_n = 2'd1;
                    end else if (cp <= 16'h07ff) begin
                        cand0  = 8'hc0 | {3'd0, cp[10:6]};
                        cand1  = 8'h80 | {2'd0, cp[5:0]};
                        cand_n = 2'd2;
                    end else begin
                        cand0  = 8'he0 | {4'd0, cp[15:12]};
                        cand1  = 8'h80 | {2'd0, cp[11:6]};
                        cand2  = 8'h80 | {2'd0, cp[5:0]};
                        cand_n = 2'd3;
                    end
                end else begin
                    n_mode  = jsu_pkg::MODE_STOP;
                    n_final = jsu_pkg::ST_ERR;
                end
            end
            default: begin
                // Stopped: hold everything until start_req.
            end
        endcase

        // Buffer space: emit while written + 1 < size and written < 32767.
        lim16 = (r_buf_size == 16'd0) ? 16'd0 : r_buf_size - 16'd1;
        lim15 = (lim16 > {1'b0, jsu_pkg::WRITTEN_MAX}) ? jsu_pkg::WRITTEN_MAX : lim16[14:0];
        room  = (lim15 > cur_written) ? lim15 - cur_written : 15'd0;
        keep  = (room >= {13'd0, cand_n}) ? cand_n : room[1:0];

        n_written = cur_written + {13'd0, keep};
        n_b0      = (keep >= 2'd1) ? cand0 : 8'd0;
        n_b1      = (keep >= 2'd2) ? cand1 : 8'd0;
        n_b2      = (keep == 2'd3) ? cand2 : 8'd0;
        n_status  = (n_mode == jsu_pkg::MODE_STOP) ? n_final : jsu_pkg::ST_RUN;
    end

    // Advance the decoder state on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_NORMAL;
            r_accum   <= 12'd0;
            r_written <= 15'd0;
            r_final   <= jsu_pkg::ST_RUN;
        end else if (in_xfer) begin
            r_mode    <= n_mode;
            r_accum   <= n_accum;
            r_written <= n_written;
            r_final   <= n_final;
        end
    end

    // Result register: load on input transfer, drop valid once drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_b0     <= n_b0;
            r_b1     <= n_b1;
            r_b2     <= n_b2;
            r_cnt    <= keep;
            r_status <= n_status;
        end
    end

    // Bytes only come out while the string is still running.
    `ASSERT_CLKED(a_bytes_only_running,
        (r_out_valid && r_cnt != 2'd0) |-> (r_status == jsu_pkg::ST_RUN),
        "bytes emitted with a final status")

    // The written count advances by exactly the bytes handed out.
    `ASSERT_CLKED(a_written_tracks_count,
        (in_xfer && !i_in.start_req) |=> (r_written == $past(r_written) + {13'd0, r_cnt}),
        "written count out of step with emitted bytes")

    // A stopped decoder yields no bytes and a final status.
    `ASSERT_CLKED(a_stop_is_quiet,
        (in_xfer && !i_in.start_req && r_mode == jsu_pkg::MODE_STOP)
            |=> (r_cnt == 2'd0 && r_status != jsu_pkg::ST_RUN),
        "stopped decoder produced output")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for json_string_unescape_core: text bytes in, decoded bytes out.
// Depends on jsu_pkg, the channel interfaces in jsu_if.sv and the core itself.

module tb_top;
    import jsu_pkg::*;

    // Stop on a hang; the slowest legal run stays far below this.
    localparam int          CYCLE_LIMIT     = 1_500_000;
    localparam logic [1:0]  REG_BUFFER_SIZE = 2'd0;
    localparam logic [15:0] BUF_SIZE_MAX    = 16'h8000;

    // One decoded result as it leaves the block.
    typedef struct packed {
        t_byte      b0;
        t_byte      b1;
        t_byte      b2;
        logic [1:0] count;
        t_status    status;
    } t_result;

    // One text byte as it enters the block.
    typedef struct packed {
        logic  start;
        t_byte c;
    } t_text_item;

    // Directed stimulus row; want is used only where fixed is set.
    typedef struct packed {
        logic    start;
        t_byte   c;
        logic    fixed;
        t_result want;
    } t_step_row;

    // Receiver behavior, picked afresh at random whenever its countdown runs out.
    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_LIGHT,
        SINK_HALF,
        SINK_SLOW
    } t_sink_mode;

    localparam t_result RUN_NONE  = '{8'h00, 8'h00, 8'h00, 2'd0, ST_RUN};
    localparam t_result DONE_NONE = '{8'h00, 8'h00, 8'h00, 2'd0, ST_DONE};
    localparam t_result ERR_NONE  = '{8'h00, 8'h00, 8'h00, 2'd0, ST_ERR};

    localparam int N_DIRECTED = 34;

    // Directed pass at the reset buffer size: start and stop, extreme bytes, every escape
    // letter, the widest \u code point with mixed-case digits, and each way to fail.
    t_step_row directed_rows [N_DIRECTED] = '{
        '{1'b1, CHR_QUOTE, 1'b1, DONE_NONE},                       // empty string
        '{1'b0, "q",       1'b1, DONE_NONE},                       // ignored, status held
        '{1'b1, CHR_NUL,   1'b1, ERR_NONE},                        // end of text
        '{1'b1, 8'hff,     1'b1, '{8'hff, 8'h00, 8'h00, 2'd1, ST_RUN}},
        '{1'b0, CHR_BSL,   1'b1, RUN_NONE},
        '{1'b0, "n",       1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, "r",       1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, "t",       1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, "b",       1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, "f",       1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, CHR_QUOTE, 1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, CHR_SLASH, 1'b0, RUN_NONE},
        '{1'b0, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, CHR_U,     1'b0, RUN_NONE},
        '{1'b0, "F",       1'b0, RUN_NONE},
        '{1'b0, "f",       1'b0, RUN_NONE},
        '{1'b0, "f",       1'b0, RUN_NONE},
        '{1'b0, "F",       1'b1, '{8'hef, 8'hbf, 8'hbf, 2'd3, ST_RUN}},
        '{1'b0, CHR_QUOTE, 1'b1, DONE_NONE},
        '{1'b1, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, "x",       1'b1, ERR_NONE},                        // unknown escape
        '{1'b1, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, CHR_NUL,   1'b1, ERR_NONE},                        // backslash at end
        '{1'b1, CHR_BSL,   1'b0, RUN_NONE},
        '{1'b0, CHR_U,     1'b0, RUN_NONE},
        '{1'b0, "g",       1'b1, ERR_NONE}                         // bad hex digit
    };

    t_byte escape_letters [8] = '{"n", "r", "t", "b", "f", CHR_QUOTE, CHR_BSL, CHR_SLASH};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    jsu_in_if  text_if ();
    jsu_out_if dec_if ();

    json_string_unescape_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_if),
        .o_out   (dec_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Decoder shadow state, advanced once per accepted text byte.
    t_mode       dec_mode;
    logic [15:0] dec_accum;
    logic [14:0] dec_written;
    t_status     dec_held;
    logic [15:0] cfg_buffer_size;

    t_result    pending_results [$];   // decoded results still owed by the block
    t_text_item text_q [$];            // text bytes waiting to be sent
    logic       next_start;

    int errors         = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int bytes_out      = 0;
    int strings_closed = 0;
    int strings_failed = 0;
    int burst_left     = 0;
    int cycle_count    = 0;

    t_sink_mode sink_mode = SINK_FREE;
    int         sink_left = 0;

    function automatic bit is_hex(input t_byte c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // Byte that a single-letter escape stands for, or -1 for an unknown letter.
    function automatic int escaped_char(input t_byte c);
        case (c)
            "n":                           return 'h0a;
            "r":                           return 'h0d;
            "t":                           return 'h09;
            "b":                           return 'h08;
            "f":                           return 'h0c;
            CHR_QUOTE, CHR_BSL, CHR_SLASH: return int'(c);
            default:                       return -1;
        endcase
    endfunction

    // Decode one text byte against the shadow state and return what the block must report.
    function automatic t_result decode_step(input logic start, input t_byte c);
        t_byte      seq [3];
        t_byte      kept [3];
        int         n;
        int         cnt;
        int         esc;
        logic [3:0] nib;
        seq  = '{8'h00, 8'h00, 8'h00};
        kept = '{8'h00, 8'h00, 8'h00};
        n    = 0;
        cnt  = 0;

        // A start marker wipes the string state before the byte is looked at.
        if (start) begin
            dec_mode    = MODE_NORMAL;
            dec_accum   = '0;
            dec_written = '0;
            dec_held    = ST_RUN;
        end

        case (dec_mode)
            MODE_NORMAL: begin
                if (c == CHR_NUL) begin
                    dec_mode = MODE_STOP;
                    dec_held = ST_ERR;
                    strings_failed++;
                end else if (c == CHR_QUOTE) begin
                    dec_mode = MODE_STOP;
                    dec_held = ST_DONE;
                    strings_closed++;
                end else if (c == CHR_BSL) begin
                    dec_mode = MODE_ESCAPE;
                end else begin
                    seq[0] = c;
                    n      = 1;
                end
            end
            MODE_ESCAPE: begin
                esc = escaped_char(c);
                if (c == CHR_U) begin
                    dec_mode  = MODE_HEX0;
                    dec_accum = '0;
                end else if (esc < 0) begin
                    dec_mode = MODE_STOP;
                    dec_held = ST_ERR;
                    strings_failed++;
                end else begin
                    dec_mode = MODE_NORMAL;
                    seq[0]   = t_byte'(esc);
                    n        = 1;
                end
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (!is_hex(c)) begin
                    dec_mode = MODE_STOP;
                    dec_held = ST_ERR;
                    strings_failed++;
                end else begin
                    // Fold case so one subtraction covers both letter ranges.
                    nib       = (c <= "9") ? 4'(c - "0") : 4'((c | 8'h20) - "a" + 10);
                    dec_accum = {dec_accum[11:0], nib};
                    if (dec_mode == MODE_HEX3) begin
                        dec_mode = MODE_NORMAL;
                        if (dec_accum <= 16'h007f) begin
                            seq[0] = dec_accum[7:0];
                            n      = 1;
                        end else if (dec_accum <= 16'h07ff) begin
                            seq[0] = {3'b110, dec_accum[10:6]};
                            seq[1] = {2'b10, dec_accum[5:0]};
                            n      = 2;
                        end else begin
                            seq[0] = {4'b1110, dec_accum[15:12]};
                            seq[1] = {2'b10, dec_accum[11:6]};
                            seq[2] = {2'b10, dec_accum[5:0]};
                            n      = 3;
                        end
                    end else begin
                        dec_mode = t_mode'(dec_mode + 3'd1);
                    end
                end
            end
            default: ;   // stopped: byte is ignored
        endcase

        // Keep leading bytes while buffer space and the write counter allow.
        for (int k = 0; k < n; k++) begin
            if (int'(dec_written) + 1 < int'(cfg_buffer_size) && dec_written < WRITTEN_MAX) begin
                kept[cnt]   = seq[k];
                dec_written = dec_written + 15'd1;
                cnt++;
            end
        end

        return '{kept[0], kept[1], kept[2], 2'(cnt),
                 (dec_mode == MODE_STOP) ? dec_held : ST_RUN};
    endfunction

    function automatic t_byte plain_char();
        t_byte c;
        do begin
            case ($urandom_range(0, 6))
                0:       c = 8'($urandom_range(8'h80, 8'hff));
                1:       c = 8'($urandom_range(8'h01, 8'h1f));
                default: c = 8'($urandom_range(8'h20, 8'h7e));
            endcase
        end while (c == CHR_QUOTE || c == CHR_BSL);
        return c;
    endfunction

    function automatic t_byte hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return t_byte'("0" + nib);
        return t_byte'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
    endfunction

    function automatic void queue_text(input t_byte c);
        text_q.push_back('{next_start, c});
        next_start = 1'b0;
    endfunction

    function automatic void queue_unicode(input logic [15:0] cp);
        queue_text(CHR_BSL);
        queue_text(CHR_U);
        queue_text(hex_char(cp[15:12]));
        queue_text(hex_char(cp[11:8]));
        queue_text(hex_char(cp[7:4]));
        queue_text(hex_char(cp[3:0]));
    endfunction

    // Queue one random string; useful counts the bytes that the decoder acts on.
    task automatic queue_string(output int useful);
        int          base;
        int          len;
        int          ending;
        logic [15:0] cp;
        t_byte       bad;
        base = text_q.size();

        // Noise: random bytes with stray start markers.
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                text_q.push_back('{($urandom_range(0, 3) == 0), 8'($urandom)});
            useful = len;
            return;
        end

        next_start = 1'b1;
        len = $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                5, 6, 7: begin
                    queue_text(CHR_BSL);
                    queue_text(escape_letters[$urandom_range(0, 7)]);
                end
                8, 9: begin
                    case ($urandom_range(0, 3))
                        0:       cp = 16'($urandom_range(16'h0000, 16'h007f));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07ff));
                        2:       cp = 16'($urandom_range(16'h0800, 16'hffff));
                        default: begin
                            case ($urandom_range(0, 5))
                                0:       cp = 16'h0000;
                                1:       cp = 16'h007f;
                                2:       cp = 16'h0080;
                                3:       cp = 16'h07ff;
                                4:       cp = 16'h0800;
                                default: cp = 16'hffff;
                            endcase
                        end
                    endcase
                    queue_unicode(cp);
                end
                default: queue_text(plain_char());
            endcase
        end

        // Mostly a closing quote; otherwise one of the broken endings.
        ending = $urandom_range(0, 15);
        case (ending)
            11: queue_text(CHR_NUL);
            12: begin
                queue_text(CHR_BSL);
                queue_text(CHR_NUL);
            end
            13: begin
                do bad = 8'($urandom);
                while (escaped_char(bad) >= 0 || bad == CHR_U || bad == CHR_NUL);
                queue_text(CHR_BSL);
                queue_text(bad);
            end
            14: begin
                queue_text(CHR_BSL);
                queue_text(CHR_U);
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++) queue_text(hex_char(4'($urandom)));
                do bad = 8'($urandom);
                while (is_hex(bad));
                queue_text(bad);
            end
            15: ;   // cut off, the next start marker abandons it
            default: queue_text(CHR_QUOTE);
        endcase
        useful = text_q.size() - base;

        // Bytes after the end are ignored by the decoder and not counted.
        if (ending != 15 && $urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) text_q.push_back('{1'b0, 8'($urandom)});
        end
    endtask

    // Drive one text byte, wait for its transfer, then record the expected result.
    task automatic send_item(input logic start, input t_byte c, input logic fixed,
                             input t_result want);
        t_result pred;
        int      gap;
        text_if.valid     <= 1'b1;
        text_if.start_req <= start;
        text_if.in_byte   <= c;
        do @(posedge i_clk); while (!text_if.ready);
        pred = decode_step(start, c);
        pending_results.push_back(fixed ? want : pred);
        items_sent++;

        // Sender paces itself in bursts; a zero gap chains bursts into long stretches.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 23);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                text_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_queued();
        t_text_item it;
        while (text_q.size() != 0) begin
            it = text_q.pop_front();
            send_item(it.start, it.c, 1'b0, RUN_NONE);
        end
    endtask

    // Drop valid and hold until every owed result has been checked.
    task automatic hold_for_results();
        text_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_items);
        int  done;
        int  useful;
        bit  paused;
        done   = 0;
        paused = 0;
        while (done < n_items) begin
            queue_string(useful);
            done += useful;
            send_queued();
            if (!paused && done >= n_items / 2) begin
                hold_for_results();
                paused = 1;
            end
        end
    endtask

    // One APB transfer: setup, then access until pready; leaves the bus idle afterwards.
    task automatic apb_access(input logic wr, input logic [15:0] data, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_BUFFER_SIZE;
        pwdata  <= {16'd0, data};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        if (wr) cfg_buffer_size = data;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_buffer_size(input logic [15:0] size);
        logic [31:0] rd;
        apb_access(1'b0, 16'd0, rd);
        if (rd !== {16'd0, size}) begin
            $display("%0t: buffer_size readback expected %08h got %08h", $time, {16'd0, size}, rd);
            errors++;
        end
    endtask

    task automatic set_buffer_size(input logic [15:0] size);
        logic [31:0] rd;
        hold_for_results();
        apb_access(1'b1, size, rd);
        check_buffer_size(size);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %02h got %02h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Receiver: ready follows a mode that is redrawn whenever its countdown runs out.
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(8, 80);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_FREE:  dec_if.ready <= 1'b1;
            SINK_LIGHT: dec_if.ready <= ($urandom_range(0, 3) != 0);
            SINK_HALF:  dec_if.ready <= 1'($urandom_range(0, 1));
            default:    dec_if.ready <= (sink_left[1:0] == 2'd0);
        endcase
    end

    // Compare each result transfer with the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && dec_if.valid && dec_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing owed, bytes %02h %02h %02h count %0d status %0d",
                         $time, dec_if.out_byte0, dec_if.out_byte1, dec_if.out_byte2,
                         dec_if.byte_count, dec_if.decode_status);
                errors++;
            end else begin
                check_field("out_byte0", pending_results[0].b0, dec_if.out_byte0);
                check_field("out_byte1", pending_results[0].b1, dec_if.out_byte1);
                check_field("out_byte2", pending_results[0].b2, dec_if.out_byte2);
                check_field("byte_count", 8'(pending_results[0].count), 8'(dec_if.byte_count));
                check_field("decode_status", 8'(pending_results[0].status),
                            8'(dec_if.decode_status));
                bytes_out += int'(pending_results[0].count);
                void'(pending_results.pop_front());
            end
        end
    end

    // Hang guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        // Every input known from time zero; reset held asserted before release.
        text_if.valid     = 1'b0;
        text_if.start_req = 1'b0;
        text_if.in_byte   = CHR_NUL;
        dec_if.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = REG_BUFFER_SIZE;
        pwdata            = '0;
        i_rst_n           = 1'b0;
        dec_mode          = MODE_NORMAL;
        dec_accum         = '0;
        dec_written       = '0;
        dec_held          = ST_RUN;
        cfg_buffer_size   = BUF_SIZE_RST;
        next_start        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_buffer_size(BUF_SIZE_RST);

        for (int r = 0; r < N_DIRECTED; r++)
            send_item(directed_rows[r].start, directed_rows[r].c, directed_rows[r].fixed,
                      directed_rows[r].want);

        // Random strings across buffer sizes, the extremes included.
        run_random(300);
        set_buffer_size(16'd1);
        run_random(100);
        set_buffer_size(16'd2);
        run_random(100);
        set_buffer_size(16'd5);
        run_random(150);
        set_buffer_size(BUF_SIZE_MAX);
        run_random(150);
        set_buffer_size(16'($urandom_range(3, 40)));
        run_random(200);

        hold_for_results();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d text bytes, checked %0d results carrying %0d decoded bytes.",
                 items_sent, results_seen, bytes_out);
        $display("Strings closed by quote: %0d, ended in error: %0d; buffer sizes 1 to 32768.",
                 strings_closed, strings_failed);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
